@@ design/mkpt_pkg.sv @@
// shared types and codes for the mac keyed profile table
`timescale 1ns / 1ps

package mkpt_pkg;

	localparam int MAC_W  = 48;
	localparam int PROF_W = 2;
	localparam int STAT_W = 2;

	localparam logic REQ_GET = 1'b0;
	localparam logic REQ_SET = 1'b1;

	localparam logic [PROF_W-1:0] PROF_STANDARD     = 2'd0;
	localparam logic [PROF_W-1:0] PROF_STRICT       = 2'd1;
	localparam logic [PROF_W-1:0] PROF_UNRESTRICTED = 2'd2;
	localparam logic [PROF_W-1:0] PROF_UNKNOWN      = 2'd3;

	localparam logic [STAT_W-1:0] STATUS_DONE        = 2'd0;
	localparam logic [STAT_W-1:0] STATUS_BAD_PROFILE = 2'd1;
	localparam logic [STAT_W-1:0] STATUS_FULL        = 2'd2;

	typedef struct packed {
		logic              req_type;
		logic [MAC_W-1:0]  mac_addr;
		logic [PROF_W-1:0] profile_in;
	} req_t;

	typedef struct packed {
		logic              found;
		logic [PROF_W-1:0] profile_out;
		logic [STAT_W-1:0] status;
	} rsp_t;

	// one table entry as it sits in the ram
	typedef struct packed {
		logic [MAC_W-1:0]  mac;
		logic [PROF_W-1:0] profile;
	} entry_t;

endpackage

@@ design/mac_keyed_profile_table.sv @@
// top level of the mac keyed profile table with its response register
//
// channel | beat    | handshake
// req     | req_t   | req_valid / req_stall
// rsp     | rsp_t   | rsp_valid / rsp_stall
//
// every request passes from acceptance through the one-entry-per-cycle scan of the entry ram,
// a tail state and a done state to the response register; one request is in work at a time,
// so a new request is accepted only after the previous one has left the done state
// reset clears the valid bits and control state; entry contents are never cleared
// a held response does not block the next request; a finished request waits only
// if the response register is still stalled

`timescale 1ns / 1ps

module mac_keyed_profile_table #(
	parameter int ENTRIES = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  mkpt_pkg::req_t req_beat,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output mkpt_pkg::rsp_t rsp_beat
);

	import mkpt_pkg::*;

	logic res_valid;
	logic res_take;
	rsp_t res_beat;
	logic rsp_valid_q;
	rsp_t rsp_q;

	mkpt_scan #(
		.ENTRIES(ENTRIES)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_beat (req_beat),
		.res_valid(res_valid),
		.res_take (res_take),
		.res_beat (res_beat)
	);

	assign res_take  = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp_beat  = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_take) begin
			rsp_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take && res_valid) begin
			rsp_q <= res_beat;
		end
	end

endmodule

@@ design/mkpt_ram.sv @@
// generic single port write, single port read ram with registered read
`timescale 1ns / 1ps

module mkpt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ design/mkpt_scan.sv @@
// request sequencer: scans the entry ram, resolves the request and writes back
`timescale 1ns / 1ps

module mkpt_scan #(
	parameter int ENTRIES = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  mkpt_pkg::req_t req_beat,
	output logic          res_valid,
	input  logic          res_take,
	output mkpt_pkg::rsp_t res_beat
);

	import mkpt_pkg::*;

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SCAN = 4'b0010,
		ST_TAIL = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t state_q;
	req_t   req_q;

	logic [ENTRIES-1:0] valid_q;
	logic [IDX_W-1:0]   idx_q;

	logic               cmp_vld_s1;
	logic [IDX_W-1:0]   cmp_idx_s1;

	logic               hit_q;
	logic [IDX_W-1:0]   hit_idx_q;
	logic [PROF_W-1:0]  hit_prof_q;
	logic               free_q;
	logic [IDX_W-1:0]   free_idx_q;

	entry_t             rd_entry;
	entry_t             wr_entry;
	logic               wr_en;
	logic [IDX_W-1:0]   wr_idx;
	logic               accept;
	logic               finish;
	logic               cmp_valid_bit;

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;
	assign res_valid = (state_q == ST_DONE);
	assign finish    = res_valid && res_take;

	assign wr_entry.mac     = req_q.mac_addr;
	assign wr_entry.profile = req_q.profile_in;

	mkpt_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(ENTRIES),
		.AW   (IDX_W)
	) u_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_idx),
		.wdata(wr_entry),
		.re   (state_q == ST_SCAN),
		.raddr(idx_q),
		.rdata(rd_entry)
	);

	assign cmp_valid_bit = valid_q[cmp_idx_s1];

	// resolve the request from the scan results
	always_comb begin
		res_beat.found       = hit_q;
		res_beat.profile_out = PROF_STANDARD;
		res_beat.status      = STATUS_DONE;
		wr_en                = 1'b0;
		wr_idx               = hit_q ? hit_idx_q : free_idx_q;
		if (req_q.req_type == REQ_GET) begin
			if (hit_q && hit_prof_q != PROF_UNKNOWN) begin
				res_beat.profile_out = hit_prof_q;
			end
		end else if (req_q.profile_in == PROF_UNKNOWN) begin
			res_beat.status = STATUS_BAD_PROFILE;
		end else if (!hit_q && !free_q) begin
			res_beat.status = STATUS_FULL;
		end else begin
			res_beat.profile_out = req_q.profile_in;
			wr_en                = finish;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			valid_q    <= '0;
			idx_q      <= '0;
			cmp_vld_s1 <= 1'b0;
			hit_q      <= 1'b0;
			free_q     <= 1'b0;
		end else begin
			cmp_vld_s1 <= (state_q == ST_SCAN);
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_SCAN;
						idx_q   <= '0;
						hit_q   <= 1'b0;
						free_q  <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (idx_q == LAST_IDX) begin
						state_q <= ST_TAIL;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_TAIL: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (finish) begin
						state_q <= ST_IDLE;
						if (wr_en) begin
							valid_q[wr_idx] <= 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			// ascending scan, so the first match and first free slot win
			if (cmp_vld_s1) begin
				if (cmp_valid_bit && rd_entry.mac == req_q.mac_addr && !hit_q) begin
					hit_q <= 1'b1;
				end
				if (!cmp_valid_bit && !free_q) begin
					free_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req_beat;
		end
		cmp_idx_s1 <= idx_q;
		if (cmp_vld_s1) begin
			if (cmp_valid_bit && rd_entry.mac == req_q.mac_addr && !hit_q) begin
				hit_idx_q  <= cmp_idx_s1;
				hit_prof_q <= rd_entry.profile;
			end
			if (!cmp_valid_bit && !free_q) begin
				free_idx_q <= cmp_idx_s1;
			end
		end
	end

endmodule
